// ----- hdl/fctg_pkg.sv -----
// Package for the floor-cast texel generator: screen and texture constants,
// fixed-point widths, configuration register codes and the divider structs.
// Depends on nothing; every other file of the block imports it.
package fctg_pkg;

  // Screen, texture and fixed-point format.
  localparam int SCREEN_W  = 640;
  localparam int SCREEN_H  = 480;
  localparam int TEX_W     = 64;
  localparam int TEX_H     = 64;
  localparam int FRAC_BITS = 16;

  // Port and register widths.
  localparam int ROW_W      = 9;
  localparam int COL_W      = 10;
  localparam int TEX_X_W    = $clog2(TEX_W);
  localparam int TEX_Y_W    = $clog2(TEX_H);
  localparam int SHADE_W    = 9;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int VEC_W      = 18;
  localparam int CAM_W      = 24;
  localparam int WORLD_W    = 40;

  // Row distance: (SCREEN_H/2) / (row - SCREEN_H/2) in Q16.
  localparam int HALF_H   = SCREEN_H / 2;
  localparam int DIST_SAT = HALF_H << FRAC_BITS;
  localparam int DIST_W   = 24;

  // Distance divider: 24-bit dividend, 9-bit divisor, one quotient bit a cycle.
  localparam int DIV_N_W   = 24;
  localparam int DIV_D_W   = 9;
  localparam int DIV_CNT_W = $clog2(DIV_N_W + 1);

  // Shared multiplier: unsigned distance or step dividend times a signed
  // operand that is wide enough to hold the step reciprocal.
  localparam int MUL_A_W = DIST_W + 1;
  localparam int MUL_B_W = 24;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // The screen width is an odd factor times a power of two. The step divide
  // is a shift by the power of two plus the format, then a divide by the odd
  // factor done as a reciprocal product. A bias keeps that dividend unsigned
  // and makes the divide floor. The reciprocal is exact for dividends below
  // 2^25 / 3, well above the biased range.
  localparam int SW_SHIFT         = 7;
  localparam int SW_ODD           = SCREEN_W >> SW_SHIFT;
  localparam int STEP_SHIFT       = FRAC_BITS + SW_SHIFT;
  localparam int STEP_OFS_EXP     = 19;
  localparam int STEP_OFS         = 1 << STEP_OFS_EXP;
  localparam int STEP_BIAS        = SW_ODD << STEP_OFS_EXP;
  localparam int STEP_RECIP_SHIFT = 25;
  localparam int STEP_RECIP       = ((1 << STEP_RECIP_SHIFT) + SW_ODD - 1) / SW_ODD;

  // Shade: 1 - 0.03 * dist, Q1.8, clamped at 0.3.
  localparam int SHADE_K       = 1966;
  localparam int SHADE_MIN     = 77;
  localparam int SHADE_ONE     = 256;
  localparam int SHADE_SHIFT   = FRAC_BITS + 8;
  localparam int SHADE_MAX_DIM = SHADE_ONE - SHADE_MIN;

  // Register reset values.
  localparam int DIR_X_RST   = 1 << FRAC_BITS;
  localparam int PLANE_Y_RST = 43254;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIR_X,
    CFG_DIR_Y,
    CFG_PLANE_X,
    CFG_PLANE_Y,
    CFG_CAM_X,
    CFG_CAM_Y
  } cfg_idx_t;

  // Divider request and response.
  typedef struct packed {
    logic               start;
    logic [DIV_N_W-1:0] dividend;
    logic [DIV_D_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DIV_N_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ----- hdl/fctg_if.sv -----
// Channel interfaces of the floor-cast texel generator: pixel items in,
// texel items out, and the configuration write channel.
// Depends on fctg_pkg for the field widths.
interface fctg_pixel_if import fctg_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ROW_W-1:0] row;
  logic [COL_W-1:0] column;

  modport source (output valid, row, column, input ready);
  modport sink   (input valid, row, column, output ready);
endinterface

interface fctg_texel_if import fctg_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ROW_W-1:0]   out_row;
  logic [COL_W-1:0]   out_column;
  logic [TEX_X_W-1:0] tex_x;
  logic [TEX_Y_W-1:0] tex_y;
  logic [SHADE_W-1:0] shade;
  logic               is_floor;

  modport source (output valid, out_row, out_column, tex_x, tex_y, shade, is_floor,
                  input ready);
  modport sink   (input valid, out_row, out_column, tex_x, tex_y, shade, is_floor,
                  output ready);
endinterface

interface fctg_cfg_if import fctg_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- hdl/fctg_div.sv -----
// Radix-2 restoring divider for the row distance: unsigned 24-bit
// dividend by a 9-bit divisor, one quotient bit per cycle.
// Depends on fctg_pkg for widths and the request/response structs.
module fctg_div import fctg_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                 run;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_D_W-1:0]   rem;
  logic [DIV_D_W-1:0]   dsr;
  logic [DIV_N_W-1:0]   quo;
  logic [DIV_D_W:0]     trial;
  logic                 fits;

  // Bring down the next dividend bit and test the divisor against it.
  always_comb begin
    trial = {rem, quo[DIV_N_W-1]};
    fits  = trial >= {1'b0, dsr};
  end

  // The dividend shifts out of quo while the quotient shifts in.
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        run <= 1'b1;
        cnt <= DIV_CNT_W'(DIV_N_W);
        rem <= '0;
        quo <= req.dividend;
        dsr <= req.divisor;
      end else if (run) begin
        rem <= fits ? DIV_D_W'(trial - {1'b0, dsr}) : trial[DIV_D_W-1:0];
        quo <= {quo[DIV_N_W-2:0], fits};
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

// ----- hdl/fctg_mul.sv -----
// Shared registered multiplier of the row setup: unsigned row distance or
// step dividend times a signed operand, product ready in the next cycle.
// Depends on fctg_pkg for the operand and product widths.
module fctg_mul import fctg_pkg::*; (
  input  logic                      clk,
  input  logic signed [MUL_A_W-1:0] a,
  input  logic signed [MUL_B_W-1:0] b,
  output logic signed [MUL_P_W-1:0] p
);

  logic signed [MUL_P_W-1:0] prod;

  // Full signed product; it always fits the product width.
  assign prod = a * b;

  always_ff @(posedge clk) begin
    p <= prod;
  end

endmodule

// ----- hdl/floor_cast_texel_generator.sv -----
// Floor-cast texel generator: turns a stream of screen pixels into floor
// texture coordinates and a distance shade.
// Depends on fctg_pkg, fctg_if, fctg_div and fctg_mul.
//
// Channels: pixel takes (row, column) items, the pixels of a row in order;
// texel returns one item per pixel; cfg writes the camera direction, plane
// and position by register index, and is always ready.
// A pixel above the horizon, or a floor pixel with a column other than 0,
// gives its result in the next cycle, and while the receiver keeps up such items
// can follow one per cycle.
// Column 0 of a floor row starts the row setup, which runs on one shared
// multiplier and one radix-2 divider under a small sequencer: a distance
// divide (24 quotient bits on the divider) and seven products, two of them
// reciprocal products that divide the steps by the odd factor of the screen
// width. On the horizon row the distance divide is skipped; pixel is not ready
// during the setup.
// The result waits in an output register; while the receiver stalls, the
// block takes no new pixel.
// Reset restores the camera registers and returns the sequencer to idle; the world
// position and steps start at zero and the row shade at 1.0.
module floor_cast_texel_generator import fctg_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  fctg_pixel_if.sink   pixel,
  fctg_texel_if.source texel,
  fctg_cfg_if.sink     cfg
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIST,
    ST_MUL,
    ST_POST,
    ST_RECIP,
    ST_STEP,
    ST_FINISH
  } state_t;

  typedef enum logic [2:0] {
    PH_SX,
    PH_SY,
    PH_WX,
    PH_WY,
    PH_SH
  } phase_t;

  state_t st;
  phase_t phase;

  // Camera registers.
  logic signed [VEC_W-1:0] dir_x, dir_y, plane_x, plane_y;
  logic [CAM_W-1:0]        cam_x, cam_y;

  // Row state.
  logic [WORLD_W-1:0] world_x, world_y, step_x, step_y;
  logic [SHADE_W-1:0] row_shade;
  logic [DIST_W-1:0]  row_dist;
  logic [DIV_N_W-1:0] step_arg;
  logic [ROW_W-1:0]   pend_row;
  logic [COL_W-1:0]   pend_col;

  // Output register.
  logic               ov;
  logic [ROW_W-1:0]   o_row;
  logic [COL_W-1:0]   o_col;
  logic [TEX_X_W-1:0] o_tx;
  logic [TEX_Y_W-1:0] o_ty;
  logic [SHADE_W-1:0] o_shade;
  logic               o_floor;

  // Shared units.
  div_req_t                  div_req;
  div_rsp_t                  div_rsp;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] mul_p;

  logic               acc;
  logic               floor_row;
  logic [ROW_W-1:0]   vp;
  logic [DIV_N_W-1:0] step_num;
  logic [WORLD_W-1:0] step_val;
  logic [WORLD_W-1:0] world_val;
  logic [MUL_P_W-SHADE_SHIFT-1:0] dim;
  logic [SHADE_W-1:0] shade_val;

  fctg_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  fctg_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  // Handshakes.
  assign pixel.ready = (st == ST_IDLE) && (!ov || texel.ready);
  assign acc         = pixel.valid && pixel.ready;
  assign cfg.ready   = 1'b1;
  assign floor_row   = pixel.row >= ROW_W'(HALF_H);
  assign vp          = pixel.row - ROW_W'(HALF_H);

  // Multiplier operands: the step dividend and its reciprocal, or the row
  // distance and the operand of the current setup phase.
  assign mul_a = (st == ST_RECIP) ? $signed({1'b0, step_arg}) : $signed({1'b0, row_dist});
  always_comb begin
    if (st == ST_RECIP) begin
      mul_b = MUL_B_W'(STEP_RECIP);
    end else begin
      unique case (phase)
        PH_SX:   mul_b = MUL_B_W'(plane_x) <<< 1;
        PH_SY:   mul_b = MUL_B_W'(plane_y) <<< 1;
        PH_WX:   mul_b = MUL_B_W'(dir_x) - MUL_B_W'(plane_x);
        PH_WY:   mul_b = MUL_B_W'(dir_y) - MUL_B_W'(plane_y);
        PH_SH:   mul_b = MUL_B_W'(SHADE_K);
        default: mul_b = '0;
      endcase
    end
  end

  // Results from the product: biased step dividend, step, world start, shade.
  always_comb begin
    step_num  = DIV_N_W'($signed(mul_p[MUL_P_W-1:STEP_SHIFT])) + DIV_N_W'(STEP_BIAS);
    step_val  = WORLD_W'(mul_p[MUL_P_W-1:STEP_RECIP_SHIFT]) - WORLD_W'(STEP_OFS);
    world_val = WORLD_W'($signed(mul_p[MUL_P_W-1:FRAC_BITS]))
              + WORLD_W'((phase == PH_WX) ? cam_x : cam_y);
    dim       = mul_p[MUL_P_W-1:SHADE_SHIFT];
    shade_val = (dim > SHADE_MAX_DIM) ? SHADE_W'(SHADE_MIN) : SHADE_W'(SHADE_ONE - dim);
  end

  // Sequencer, row state, configuration and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      st            <= ST_IDLE;
      phase         <= PH_SX;
      ov            <= 1'b0;
      div_req.start <= 1'b0;
      dir_x         <= VEC_W'(DIR_X_RST);
      dir_y         <= '0;
      plane_x       <= '0;
      plane_y       <= VEC_W'(PLANE_Y_RST);
      cam_x         <= '0;
      cam_y         <= '0;
      world_x       <= '0;
      world_y       <= '0;
      step_x        <= '0;
      step_y        <= '0;
      row_shade     <= SHADE_W'(SHADE_ONE);
    end else begin
      div_req.start <= 1'b0;

      if (ov && texel.ready) begin
        ov <= 1'b0;
      end

      if (cfg.valid) begin
        unique case (cfg_idx_t'(cfg.index))
          CFG_DIR_X:   dir_x   <= cfg.data[VEC_W-1:0];
          CFG_DIR_Y:   dir_y   <= cfg.data[VEC_W-1:0];
          CFG_PLANE_X: plane_x <= cfg.data[VEC_W-1:0];
          CFG_PLANE_Y: plane_y <= cfg.data[VEC_W-1:0];
          CFG_CAM_X:   cam_x   <= cfg.data[CAM_W-1:0];
          CFG_CAM_Y:   cam_y   <= cfg.data[CAM_W-1:0];
          default: ;
        endcase
      end

      unique case (st)
        ST_IDLE: begin
          if (acc) begin
            if (!floor_row) begin
              // Above the horizon: flagged, nothing else happens.
              ov      <= 1'b1;
              o_row   <= pixel.row;
              o_col   <= pixel.column;
              o_tx    <= '0;
              o_ty    <= '0;
              o_shade <= '0;
              o_floor <= 1'b0;
            end else if (pixel.column == '0) begin
              // New floor row; the horizon row takes the saturated distance.
              pend_row <= pixel.row;
              pend_col <= pixel.column;
              phase    <= PH_SX;
              if (vp == '0) begin
                row_dist <= DIST_W'(DIST_SAT);
                st       <= ST_MUL;
              end else begin
                div_req.start    <= 1'b1;
                div_req.dividend <= DIV_N_W'(DIST_SAT);
                div_req.divisor  <= vp;
                st               <= ST_DIST;
              end
            end else begin
              // Floor pixel inside a row: sample, then step.
              ov      <= 1'b1;
              o_row   <= pixel.row;
              o_col   <= pixel.column;
              o_tx    <= world_x[FRAC_BITS-1 -: TEX_X_W];
              o_ty    <= world_y[FRAC_BITS-1 -: TEX_Y_W];
              o_shade <= row_shade;
              o_floor <= 1'b1;
              world_x <= world_x + step_x;
              world_y <= world_y + step_y;
            end
          end
        end

        ST_DIST: begin
          if (div_rsp.done) begin
            row_dist <= div_rsp.quotient[DIST_W-1:0];
            st       <= ST_MUL;
          end
        end

        // Operands settle into the multiplier this cycle.
        ST_MUL: begin
          st <= ST_POST;
        end

        ST_POST: begin
          unique case (phase)
            PH_SX, PH_SY: begin
              step_arg <= step_num;
              st       <= ST_RECIP;
            end
            PH_WX: begin
              world_x <= world_val;
              phase   <= PH_WY;
              st      <= ST_MUL;
            end
            PH_WY: begin
              world_y <= world_val;
              phase   <= PH_SH;
              st      <= ST_MUL;
            end
            PH_SH: begin
              row_shade <= shade_val;
              st        <= ST_FINISH;
            end
            default: st <= ST_IDLE;
          endcase
        end

        // The biased step dividend times the reciprocal of the odd factor.
        ST_RECIP: begin
          st <= ST_STEP;
        end

        ST_STEP: begin
          if (phase == PH_SX) begin
            step_x <= step_val;
            phase  <= PH_SY;
          end else begin
            step_y <= step_val;
            phase  <= PH_WX;
          end
          st <= ST_MUL;
        end

        // First pixel of the row from the fresh setup.
        ST_FINISH: begin
          ov      <= 1'b1;
          o_row   <= pend_row;
          o_col   <= pend_col;
          o_tx    <= world_x[FRAC_BITS-1 -: TEX_X_W];
          o_ty    <= world_y[FRAC_BITS-1 -: TEX_Y_W];
          o_shade <= row_shade;
          o_floor <= 1'b1;
          world_x <= world_x + step_x;
          world_y <= world_y + step_y;
          st      <= ST_IDLE;
        end

        default: st <= ST_IDLE;
      endcase
    end
  end

  assign texel.valid      = ov;
  assign texel.out_row    = o_row;
  assign texel.out_column = o_col;
  assign texel.tex_x      = o_tx;
  assign texel.tex_y      = o_ty;
  assign texel.shade      = o_shade;
  assign texel.is_floor   = o_floor;

  // The divider only finishes while the sequencer waits for it.
  a_div_done_expected: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (st == ST_DIST))
    else $error("divider finished outside a wait state");

  // A row setup item gives no result in the next cycle.
  a_setup_no_early_result: assert property (@(posedge clk) disable iff (rst)
    (acc && floor_row && pixel.column == '0) |=> !texel.valid)
    else $error("result appeared before the row setup finished");

  // The setup result never lands on an occupied output register.
  a_finish_output_free: assert property (@(posedge clk) disable iff (rst)
    (st == ST_FINISH) |-> !ov)
    else $error("output register busy when the row setup finished");

  // Floor shade stays within its clamp range.
  a_floor_shade_range: assert property (@(posedge clk) disable iff (rst)
    (texel.valid && texel.is_floor) |->
      (texel.shade >= SHADE_W'(SHADE_MIN) && texel.shade <= SHADE_W'(SHADE_ONE)))
    else $error("floor shade out of range");

  // Items above the horizon carry no texture or shade.
  a_sky_zero: assert property (@(posedge clk) disable iff (rst)
    (texel.valid && !texel.is_floor) |->
      (texel.shade == '0 && texel.tex_x == '0 && texel.tex_y == '0))
    else $error("non-floor item with texture fields set");

endmodule

// ----- dv/tb_top.sv -----
// Testbench for floor_cast_texel_generator: drives pixel items through random and
// directed camera settings and checks every texel item against an in-bench predictor.
// Depends on fctg_pkg, the fctg channel interfaces and the block's RTL.
`timescale 1ns / 100ps

module tb_top;
  import fctg_pkg::*;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] column;
  } pixel_t;

  typedef struct packed {
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   column;
    logic [TEX_X_W-1:0] tex_x;
    logic [TEX_Y_W-1:0] tex_y;
    logic [SHADE_W-1:0] shade;
    logic               is_floor;
  } texel_t;

  logic clk;
  logic rst;

  fctg_pixel_if pix ();
  fctg_texel_if txl ();
  fctg_cfg_if   cfg_wr ();

  floor_cast_texel_generator DUT (
    .clk    (clk),
    .rst    (rst),
    .pixel  (pix),
    .texel  (txl),
    .cfg    (cfg_wr)
  );

  // Pixels waiting to be offered, and texels predicted but not yet seen.
  pixel_t pixels_to_send[$];
  texel_t texels_due[$];

  // Camera registers as the block should hold them.
  longint cam_dir_x, cam_dir_y, cam_plane_x, cam_plane_y, cam_pos_x, cam_pos_y;

  // Row state: world position, per-pixel step and row shade.
  logic [WORLD_W-1:0] wx_acc, wy_acc, wx_step, wy_step;
  logic [SHADE_W-1:0] cur_shade;

  int error_count;
  bit tx_quiet;
  bit rx_quiet;
  bit rx_hold;
  bit stall_go;

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Run limit, far above the slowest correct run.
  initial begin
    #36_000_000;
    $display("tb_top: errors");
    $finish;
  end

  task automatic report_mismatch(string msg);
    error_count++;
    $display("tb_top mismatch at %0t: %s", $time, msg);
  endtask

  task automatic check_field(string name, logic [COL_W-1:0] got, logic [COL_W-1:0] want,
                             texel_t ctx);
    if (got !== want)
      report_mismatch($sformatf("row %0d column %0d: %s is %0d, expected %0d",
                                ctx.row, ctx.column, name, got, want));
  endtask

  // Division rounded toward minus infinity, for a positive divisor.
  function automatic longint floor_div(longint n, longint d);
    longint q = n / d;
    if (n % d != 0 && n < 0) q--;
    return q;
  endfunction

  // One random configuration word.
  function automatic logic [CFG_DATA_W-1:0] rand_word();
    return CFG_DATA_W'($urandom());
  endfunction

  // Works out the texel for one accepted pixel and advances the row state.
  function automatic void predict_texel(logic [ROW_W-1:0] r, logic [COL_W-1:0] c);
    texel_t t;
    longint span;
    longint row_dist;
    longint dim;
    t = '0;
    t.row = r;
    t.column = c;
    if (r >= HALF_H) begin
      // Column 0 sets the row up; the horizon row saturates the distance.
      if (c == 0) begin
        span = longint'(r) - HALF_H;
        row_dist = (span == 0) ? DIST_SAT : DIST_SAT / span;
        wx_step = WORLD_W'(floor_div(row_dist * 2 * cam_plane_x,
                                     longint'(SCREEN_W) << FRAC_BITS));
        wy_step = WORLD_W'(floor_div(row_dist * 2 * cam_plane_y,
                                     longint'(SCREEN_W) << FRAC_BITS));
        wx_acc = WORLD_W'(cam_pos_x + floor_div(row_dist * (cam_dir_x - cam_plane_x),
                                                longint'(1) << FRAC_BITS));
        wy_acc = WORLD_W'(cam_pos_y + floor_div(row_dist * (cam_dir_y - cam_plane_y),
                                                longint'(1) << FRAC_BITS));
        dim = (row_dist * SHADE_K) >>> SHADE_SHIFT;
        cur_shade = (dim > SHADE_MAX_DIM) ? SHADE_W'(SHADE_MIN) : SHADE_W'(SHADE_ONE - dim);
      end
      t.tex_x = wx_acc[FRAC_BITS-1 -: TEX_X_W];
      t.tex_y = wy_acc[FRAC_BITS-1 -: TEX_Y_W];
      t.shade = cur_shade;
      t.is_floor = 1'b1;
      wx_acc = wx_acc + wx_step;
      wy_acc = wy_acc + wy_step;
    end
    texels_due.push_back(t);
  endfunction

  // Pixel driver: offers the next pending item once the current one is taken.
  always @(posedge clk) begin : pixel_driver
    pixel_t nxt;
    if (rst) begin
      pix.valid <= 1'b0;
    end else begin
      if (pix.valid && pix.ready) predict_texel(pix.row, pix.column);
      if (!pix.valid || pix.ready) begin
        if (pixels_to_send.size() != 0 && (tx_quiet || $urandom_range(99) >= 6)) begin
          nxt = pixels_to_send.pop_front();
          pix.valid <= 1'b1;
          pix.row <= nxt.row;
          pix.column <= nxt.column;
        end else begin
          pix.valid <= 1'b0;
        end
      end
    end
  end

  // Texel monitor: checks each taken item against the oldest prediction.
  always @(posedge clk) begin : texel_monitor
    texel_t want;
    if (rst) begin
      txl.ready <= 1'b0;
    end else begin
      if (txl.valid && txl.ready) begin
        if (texels_due.size() == 0) begin
          report_mismatch($sformatf("texel item row %0d column %0d with none expected",
                                    txl.out_row, txl.out_column));
        end else begin
          want = texels_due.pop_front();
          check_field("out_row", COL_W'(txl.out_row), COL_W'(want.row), want);
          check_field("out_column", txl.out_column, want.column, want);
          check_field("tex_x", COL_W'(txl.tex_x), COL_W'(want.tex_x), want);
          check_field("tex_y", COL_W'(txl.tex_y), COL_W'(want.tex_y), want);
          check_field("shade", COL_W'(txl.shade), COL_W'(want.shade), want);
          check_field("is_floor", COL_W'(txl.is_floor), COL_W'(want.is_floor), want);
        end
      end
      txl.ready <= !rx_hold && (rx_quiet || $urandom_range(99) >= 6);
    end
  end

  // Long receiver hold-off, so the output register fills and pixel stalls.
  initial begin : long_stall
    wait (stall_go);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (400) @(posedge clk);
    rx_hold <= 1'b0;
  end

  // Queues n pixels of one row, columns counting up from c0.
  task automatic add_row(int r, int c0, int n);
    pixel_t p;
    for (int i = 0; i < n; i++) begin
      p.row = ROW_W'(r);
      p.column = COL_W'(c0 + i);
      pixels_to_send.push_back(p);
    end
  endtask

  // Mostly well-formed floor rows with random content, plus broken rows and noise.
  task automatic add_traffic(int n);
    int added;
    int kind;
    int len;
    int r;
    added = 0;
    while (added < n) begin
      kind = $urandom_range(99);
      if (kind < 65) begin
        r = ($urandom_range(9) == 0) ? $urandom_range(SCREEN_H, 511)
                                     : $urandom_range(HALF_H, SCREEN_H - 1);
        len = ($urandom_range(15) == 0) ? $urandom_range(40, 90) : $urandom_range(1, 24);
        add_row(r, 0, len);
      end else if (kind < 78) begin
        len = $urandom_range(1, 6);
        add_row($urandom_range(HALF_H - 1), $urandom_range(1023), len);
      end else if (kind < 90) begin
        // Floor pixels that continue whatever row was set up last.
        len = $urandom_range(1, 8);
        add_row($urandom_range(HALF_H, 511), $urandom_range(1, 1023), len);
      end else begin
        len = 1;
        add_row($urandom_range(511), $urandom_range(1023), 1);
      end
      added += len;
    end
  endtask

  // Writes all six camera registers; called while the block is idle.
  task automatic write_camera(logic [CFG_DATA_W-1:0] dx, logic [CFG_DATA_W-1:0] dy,
                              logic [CFG_DATA_W-1:0] px, logic [CFG_DATA_W-1:0] py,
                              logic [CFG_DATA_W-1:0] cx, logic [CFG_DATA_W-1:0] cy);
    logic [CFG_DATA_W-1:0] vals[6];
    cfg_idx_t idx;
    vals = '{dx, dy, px, py, cx, cy};
    @(posedge clk);
    for (int i = 0; i < 6; i++) begin
      idx = cfg_idx_t'(i);
      cfg_wr.valid <= 1'b1;
      cfg_wr.index <= idx;
      cfg_wr.data <= vals[i];
      @(posedge clk);
      while (!cfg_wr.ready) @(posedge clk);
      case (idx)
        CFG_DIR_X:   cam_dir_x = longint'($signed(vals[i][VEC_W-1:0]));
        CFG_DIR_Y:   cam_dir_y = longint'($signed(vals[i][VEC_W-1:0]));
        CFG_PLANE_X: cam_plane_x = longint'($signed(vals[i][VEC_W-1:0]));
        CFG_PLANE_Y: cam_plane_y = longint'($signed(vals[i][VEC_W-1:0]));
        CFG_CAM_X:   cam_pos_x = longint'(vals[i][CAM_W-1:0]);
        CFG_CAM_Y:   cam_pos_y = longint'(vals[i][CAM_W-1:0]);
        default:     ;
      endcase
    end
    cfg_wr.valid <= 1'b0;
    @(negedge clk);
  endtask

  // Waits until every pixel is taken and every texel has come, then lets
  // a full row setup's worth of cycles pass.
  task automatic wait_idle();
    while (pixels_to_send.size() != 0 || pix.valid || texels_due.size() != 0)
      @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  // Main sequence: reset, directed pixels, then phases of camera settings.
  initial begin
    rst = 1'b1;
    pix.valid = 1'b0;
    pix.row = '0;
    pix.column = '0;
    txl.ready = 1'b0;
    cfg_wr.valid = 1'b0;
    cfg_wr.index = CFG_DIR_X;
    cfg_wr.data = '0;
    error_count = 0;
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
    rx_hold = 1'b0;
    stall_go = 1'b0;
    cam_dir_x = DIR_X_RST;
    cam_dir_y = 0;
    cam_plane_x = 0;
    cam_plane_y = PLANE_Y_RST;
    cam_pos_x = 0;
    cam_pos_y = 0;
    wx_acc = '0;
    wy_acc = '0;
    wx_step = '0;
    wy_step = '0;
    cur_shade = SHADE_W'(SHADE_ONE);
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed pixels under the reset camera.
    add_row(0, 0, 2);
    add_row(HALF_H - 1, 1023, 1);
    add_row(300, 7, 2);                 // floor pixels before any setup
    add_row(HALF_H, 0, 3);              // horizon row
    add_row(HALF_H + 1, 0, 2);          // largest regular distance
    add_row(SCREEN_H - 1, 0, 2);
    add_row(SCREEN_H - 1, SCREEN_W - 1, 1);
    add_row(511, 0, 2);                 // rows below the screen
    add_row(SCREEN_H, 0, 1);
    add_row(350, 0, 3);
    add_row(100, 3, 1);                 // sky pixel inside a floor row
    add_row(350, 3, 2);
    add_row(SCREEN_H - 1, 1022, 3);     // columns past the screen, wrapping to 0
    wait_idle();

    // Extreme camera settings.
    write_camera(24'h01FFFF, 24'h01FFFF, 24'h01FFFF, 24'h01FFFF, 24'hFFFFFF, 24'hFFFFFF);
    add_traffic(130);
    wait_idle();
    write_camera(24'h020000, 24'h020000, 24'h020000, 24'h020000, 24'h000000, 24'h000000);
    add_traffic(130);
    wait_idle();
    write_camera(24'hFE0001, 24'hFE0000, 24'h020000, 24'h01FFFF, 24'hFFFFFF, 24'h000000);
    stall_go = 1'b1;
    add_traffic(130);
    wait_idle();

    // One full screen row with no idling on either side.
    write_camera(rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
                 rand_word());
    tx_quiet = 1'b1;
    rx_quiet = 1'b1;
    add_row(SCREEN_H - 1, 0, SCREEN_W);
    add_traffic(60);
    wait_idle();
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;

    // Random camera settings.
    repeat (4) begin
      write_camera(rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
                   rand_word());
      add_traffic(110);
      wait_idle();
    end

    if (error_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
